// File: rtl/core/pcxrle_pkg.sv
// shared types and constants for the pcx run-length scan-line decoder
// no dependencies; used by pcxrle_item_fifo and pcx_rle_scanline_decoder_unit

package pcxrle_pkg;

    // byte values at or above this mark a run
    localparam logic [7:0] RUN_MARK = 8'd192;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_LINE = 2'd0,
        CFG_IMAGE_WIDTH    = 2'd1,
        CFG_SCANLINE_SIZE  = 2'd2
    } t_cfg_idx;

    localparam int unsigned CFG_W    = 16;
    localparam int unsigned COLUMN_W = 17;
    localparam int unsigned RUN_W    = 6;

    // one result item
    typedef struct packed {
        logic [7:0]       pixel_value;
        logic [CFG_W-1:0] repeat_count;
        logic             is_padding;
        logic             line_end;
        logic             last;
    } t_item;

    // write side of the result queue: up to two items per cycle
    typedef struct packed {
        logic [1:0] num;
        t_item      item0;
        t_item      item1;
    } t_push;

endpackage

// File: rtl/core/pcx_rle_scanline_decoder_unit.sv
// top level of the pcx run-length scan-line decoder
// depends on pcxrle_pkg and pcxrle_item_fifo

// usage
//   input channel: one encoded data byte per item (i_in_byte, after the file
//   header), handshake i_in_valid / o_in_stall
//   output channel: result items (pixel, count, padding, line end, last),
//   handshake o_out_valid / i_out_stall
//   config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle
// latency and throughput
//   a byte is decoded in the cycle it is accepted and its items are written
//   to the registered result queue, which gives one item per cycle while the
//   output is not stalled; one byte per cycle is taken while the queue has
//   room for two items; a byte that ends a line with a pixel and padding
//   yields two items, so the sustained output is bounded by the single
//   queue read port
// reset
//   clears the run state, the column and the queue; registers go to 640
// stall
//   a stalled output holds its item; once the queue cannot take two more
//   items the input is stalled; the queue holds QUEUE_DEPTH entries

module pcx_rle_scanline_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config port
    input  logic                                 i_cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_in_byte,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [7:0]                           o_pixel_value,
    output logic [pcxrle_pkg::CFG_W-1:0]         o_repeat_count,
    output logic                                 o_is_padding,
    output logic                                 o_line_end,
    output logic                                 o_last
);

    localparam int unsigned CW = pcxrle_pkg::COLUMN_W;
    localparam int unsigned RW = pcxrle_pkg::RUN_W;
    localparam int unsigned FW = pcxrle_pkg::CFG_W;

    // configuration registers
    logic [FW-1:0] r_bytes_per_line;
    logic [FW-1:0] r_image_width;
    logic [FW-1:0] r_scanline_size;

    // decode state
    logic          r_run_pending, n_run_pending;
    logic [RW-1:0] r_pending_count, n_pending_count;
    logic [CW-1:0] r_column, n_column;

    logic              in_accept;
    logic              is_marker;
    logic [CW-1:0]     count;
    logic              emit_pix;
    logic [CW-1:0]     col_sum;
    logic              line_done;
    logic              pad_needed;
    logic              pad_item;
    logic [FW-1:0]     pad_len;
    pcxrle_pkg::t_item pix_it, pad_it;
    pcxrle_pkg::t_push push;
    pcxrle_pkg::t_item head;
    logic              q_not_empty;
    logic              q_room2;
    logic              pop;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = !q_room2;

    // config writes; an index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_line <= FW'(640);
            r_image_width    <= FW'(640);
            r_scanline_size  <= FW'(640);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcxrle_pkg::CFG_BYTES_PER_LINE: r_bytes_per_line <= i_cfg_data;
                pcxrle_pkg::CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                pcxrle_pkg::CFG_SCANLINE_SIZE:  r_scanline_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode of one byte
    always_comb begin
        is_marker = !r_run_pending && (i_in_byte >= pcxrle_pkg::RUN_MARK);
        // a pending run repeats this byte, otherwise it is one literal
        count     = r_run_pending ? CW'(r_pending_count) : CW'(1);
        // column before the byte decides whether the pixel is visible
        emit_pix  = (count != '0) && (r_column < CW'(r_image_width));
        col_sum   = r_column + count;
        line_done = (col_sum >= CW'(r_bytes_per_line));
        pad_needed = (col_sum < CW'(r_scanline_size));
        // padding item also marks a line end that has no pixel item to carry it
        pad_item  = line_done && (pad_needed || !emit_pix);
        pad_len   = pad_needed ? (r_scanline_size - col_sum[FW-1:0]) : '0;

        pix_it.pixel_value  = i_in_byte;
        pix_it.repeat_count = count[FW-1:0];
        pix_it.is_padding   = 1'b0;
        pix_it.line_end     = line_done && !pad_needed;
        pix_it.last         = !pad_item;

        pad_it.pixel_value  = 8'd0;
        pad_it.repeat_count = pad_len;
        pad_it.is_padding   = 1'b1;
        pad_it.line_end     = 1'b1;
        pad_it.last         = 1'b1;

        push.num   = 2'd0;
        push.item0 = emit_pix ? pix_it : pad_it;
        push.item1 = pad_it;
        if (in_accept && !is_marker) begin
            push.num = {1'b0, emit_pix} + {1'b0, pad_item};
        end

        n_run_pending   = r_run_pending;
        n_pending_count = r_pending_count;
        n_column        = r_column;
        if (in_accept) begin
            if (is_marker) begin
                n_run_pending   = 1'b1;
                n_pending_count = i_in_byte[RW-1:0];
            end else begin
                n_run_pending   = 1'b0;
                n_pending_count = '0;
                // overshoot past the line end is discarded
                n_column        = line_done ? '0 : col_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending   <= 1'b0;
            r_pending_count <= '0;
            r_column        <= '0;
        end else begin
            r_run_pending   <= n_run_pending;
            r_pending_count <= n_pending_count;
            r_column        <= n_column;
        end
    end

    // result queue parts the decoder from the output handshake
    assign pop = q_not_empty && !i_out_stall;

    pcxrle_item_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .o_item      (head),
        .o_not_empty (q_not_empty),
        .o_room2     (q_room2)
    );

    assign o_out_valid    = q_not_empty;
    assign o_pixel_value  = head.pixel_value;
    assign o_repeat_count = head.repeat_count;
    assign o_is_padding   = head.is_padding;
    assign o_line_end     = head.line_end;
    assign o_last         = head.last;

endmodule

// File: rtl/core/pcxrle_item_fifo.sv
// small result queue that takes up to two items per cycle and gives one
// depends on pcxrle_pkg for the item and push types

module pcxrle_item_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcxrle_pkg::t_push    i_push,
    input  logic                 i_pop,
    output pcxrle_pkg::t_item    o_item,
    output logic                 o_not_empty,
    output logic                 o_room2
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    pcxrle_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  wr_ptr_p1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_p1   = ptr_inc(r_wr_ptr);
    assign o_item      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_room2     = (r_count <= ROOM_MAX);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.num == 2'd1) begin
            n_wr_ptr = wr_ptr_p1;
        end else if (i_push.num == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr_p1);
        end
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.num) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: tb/pcx_rle_scanline_checker.sv
// checker for the pcx run-length scan-line decoder: predicts result items and compares them
// watches the config port and both channels; depends on pcxrle_pkg

module pcx_rle_scanline_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [7:0]                       i_pixel_value,
    input  logic [pcxrle_pkg::CFG_W-1:0]     i_repeat_count,
    input  logic                             i_is_padding,
    input  logic                             i_line_end,
    input  logic                             i_last,
    input  logic                             i_final_check,
    output int                               o_fail_cnt,
    output int                               o_outstanding,
    output int                               o_bytes_seen,
    output int                               o_items_seen,
    output int                               o_pads_seen,
    output int                               o_lines_seen
);
    import pcxrle_pkg::*;

    // decoder state and register copies
    logic [CFG_W-1:0]    cfg_bpl;
    logic [CFG_W-1:0]    cfg_iw;
    logic [CFG_W-1:0]    cfg_ssz;
    logic                mark_pend;
    logic [RUN_W-1:0]    mark_cnt;
    logic [COLUMN_W-1:0] line_col;

    t_item predicted_items [$];

    int  fail_cnt   = 0;
    int  queued     = 0;
    int  bytes_seen = 0;
    int  items_seen = 0;
    int  pads_seen  = 0;
    int  lines_seen = 0;
    bit  final_done = 1'b0;

    assign o_fail_cnt    = fail_cnt;
    assign o_outstanding = queued;
    assign o_bytes_seen  = bytes_seen;
    assign o_items_seen  = items_seen;
    assign o_pads_seen   = pads_seen;
    assign o_lines_seen  = lines_seen;

    task automatic report_mismatch(input string what);
        if (fail_cnt < 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        fail_cnt++;
    endtask

    // one encoded byte in, zero to two result items queued
    task automatic decode_byte(input logic [7:0] b);
        logic [COLUMN_W-1:0] run_len;
        logic [COLUMN_W-1:0] shortfall;
        t_item               pix;
        t_item               pad;
        bit                  have_pix;
        bit                  have_pad;

        pix      = '0;
        pad      = '0;
        have_pix = 1'b0;
        have_pad = 1'b0;
        if (!mark_pend && b >= RUN_MARK) begin
            mark_pend = 1'b1;
            mark_cnt  = b[RUN_W-1:0];
        end else begin
            run_len   = mark_pend ? COLUMN_W'(mark_cnt) : COLUMN_W'(1);
            mark_pend = 1'b0;
            mark_cnt  = '0;

            // drop anything starting at or past the visible width
            if (run_len != 0 && line_col < {1'b0, cfg_iw}) begin
                have_pix         = 1'b1;
                pix.pixel_value  = b;
                pix.repeat_count = run_len[CFG_W-1:0];
            end
            line_col = line_col + run_len;

            if (line_col >= {1'b0, cfg_bpl}) begin
                pad.is_padding = 1'b1;
                pad.line_end   = 1'b1;
                if (line_col < {1'b0, cfg_ssz}) begin
                    shortfall        = {1'b0, cfg_ssz} - line_col;
                    have_pad         = 1'b1;
                    pad.repeat_count = shortfall[CFG_W-1:0];
                end else if (have_pix) begin
                    pix.line_end = 1'b1;
                end else begin
                    // zero-length marker for the line end
                    have_pad = 1'b1;
                end
                line_col = '0;
            end

            if (have_pad) begin
                pad.last = 1'b1;
            end else if (have_pix) begin
                pix.last = 1'b1;
            end
            if (have_pix) predicted_items.push_back(pix);
            if (have_pad) predicted_items.push_back(pad);
        end
    endtask

    task automatic compare_item();
        t_item want;

        if (predicted_items.size() == 0) begin
            report_mismatch($sformatf("item with nothing expected: pixel %0d count %0d pad %0b",
                                      i_pixel_value, i_repeat_count, i_is_padding));
        end else begin
            want = predicted_items.pop_front();
            if (i_pixel_value !== want.pixel_value)
                report_mismatch($sformatf("pixel_value got %0d want %0d",
                                          i_pixel_value, want.pixel_value));
            if (i_repeat_count !== want.repeat_count)
                report_mismatch($sformatf("repeat_count got %0d want %0d",
                                          i_repeat_count, want.repeat_count));
            if (i_is_padding !== want.is_padding)
                report_mismatch($sformatf("is_padding got %b want %b",
                                          i_is_padding, want.is_padding));
            if (i_line_end !== want.line_end)
                report_mismatch($sformatf("line_end got %b want %b",
                                          i_line_end, want.line_end));
            if (i_last !== want.last)
                report_mismatch($sformatf("last got %b want %b", i_last, want.last));
        end
        items_seen++;
        if (i_is_padding === 1'b1) pads_seen++;
        if (i_line_end === 1'b1) lines_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_bpl   = 16'd640;
            cfg_iw    = 16'd640;
            cfg_ssz   = 16'd640;
            mark_pend = 1'b0;
            mark_cnt  = '0;
            line_col  = '0;
            predicted_items.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BYTES_PER_LINE: cfg_bpl = i_cfg_data;
                    CFG_IMAGE_WIDTH:    cfg_iw  = i_cfg_data;
                    CFG_SCANLINE_SIZE:  cfg_ssz = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_byte);
                bytes_seen++;
            end
            if (i_out_valid && !i_out_stall) compare_item();
            if (i_final_check && !final_done) begin
                final_done = 1'b1;
                while (predicted_items.size() != 0) begin
                    void'(predicted_items.pop_front());
                    report_mismatch("expected item never arrived");
                end
            end
        end
        queued = predicted_items.size();
    end

endmodule

// File: tb/tb_pcx_rle_scanline_decoder_unit.sv
// testbench top for pcx_rle_scanline_decoder_unit: stimulus, output stall and verdict
// depends on pcxrle_pkg, the decoder rtl and pcx_rle_scanline_checker

module tb_pcx_rle_scanline_decoder_unit;
    import pcxrle_pkg::*;

    // idle modes for the two sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int HOLD_LEN    = 300;       // long output hold, in cycles
    localparam int DRAIN_LIMIT = 20000;     // cycles allowed for results to come out
    localparam int SETTLE      = 8;         // quiet cycles once nothing is expected
    localparam int RUN_LIMIT   = 2000000;   // overall time limit

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_BYTES_PER_LINE;
    logic [CFG_W-1:0]   cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte      = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [7:0]         pixel_value;
    logic [CFG_W-1:0]   repeat_count;
    logic               is_padding;
    logic               line_end;
    logic               item_last;
    logic               final_check  = 1'b0;
    logic               pressure_on  = 1'b0;

    int fail_cnt;
    int outstanding;
    int bytes_seen;
    int items_seen;
    int pads_seen;
    int lines_seen;

    int gap_pct      = 0;   // chance per cycle that the sender idles
    int stall_pct    = 0;   // chance per cycle that the receiver stalls
    int settings_cnt = 0;
    int hold_cycles  = 0;
    bit hold_done    = 1'b0;

    // literals at both ends, zero-count run, full 63 run with overshoot,
    // marker byte used as run color, dropped items past the width
    byte unsigned directed_seq [20] = '{
        8'h00, 8'hBF, 8'hC0, 8'h55, 8'hC3, 8'hFF, 8'h11, 8'hC2, 8'h22, 8'hFF,
        8'h80, 8'hC1, 8'hC1, 8'h7F, 8'h01, 8'h40, 8'hC0, 8'hC0, 8'hFE, 8'h00
    };

    always #2 clk = ~clk;

    pcx_rle_scanline_decoder_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_value  (pixel_value),
        .o_repeat_count (repeat_count),
        .o_is_padding   (is_padding),
        .o_line_end     (line_end),
        .o_last         (item_last)
    );

    pcx_rle_scanline_checker decode_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pixel_value  (pixel_value),
        .i_repeat_count (repeat_count),
        .i_is_padding   (is_padding),
        .i_line_end     (line_end),
        .i_last         (item_last),
        .i_final_check  (final_check),
        .o_fail_cnt     (fail_cnt),
        .o_outstanding  (outstanding),
        .o_bytes_seen   (bytes_seen),
        .o_items_seen   (items_seen),
        .o_pads_seen    (pads_seen),
        .o_lines_seen   (lines_seen)
    );

    // receiver: random stall, or one long hold while pressure is on so the
    // result queue fills and the input side has to stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (pressure_on && !hold_done) begin
            out_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one item, with random idle cycles ahead of it, and wait until
    // it is taken; valid stays high into the next item when there is no gap
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // mostly well-formed data: run marker plus color, or a literal;
    // the rest is arbitrary bytes, which may start a run or not
    task automatic send_random(input int n);
        int sent;
        int kind;
        logic [7:0] mark;

        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // short runs are common so that lines end at small sizes
                mark = 8'(192 + ($urandom_range(1) ? $urandom_range(7) : $urandom_range(63)));
                send_byte(mark);
                send_byte(8'($urandom_range(255)));
                sent += 2;
            end else if (kind < 90) begin
                send_byte(8'($urandom_range(191)));
                sent++;
            end else begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
        stop_sending();
    endtask

    // wait until every predicted item has come out, then let it settle,
    // since a trailing run marker produces nothing but may still be in flight
    task automatic wait_quiet();
        int n;

        n = 0;
        // wait for a clock edge first so the checker has seen the last accepted byte
        @(posedge clk);
        while (outstanding != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // all three registers, one write per cycle, only while idle
    task automatic set_regs(input logic [CFG_W-1:0] bpl, input logic [CFG_W-1:0] iw,
                            input logic [CFG_W-1:0] ssz);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BYTES_PER_LINE;
        cfg_data  <= bpl;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= iw;
        @(posedge clk);
        cfg_index <= CFG_SCANLINE_SIZE;
        cfg_data  <= ssz;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_cnt++;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            IDLE_SEND: begin gap_pct = 58; stall_pct = 0;  end
            IDLE_RECV: begin gap_pct = 0;  stall_pct = 58; end
            IDLE_BOTH: begin gap_pct = 16; stall_pct = 16; end
            default:   begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] bpl, input logic [CFG_W-1:0] iw,
                             input logic [CFG_W-1:0] ssz, input int mode, input int n);
        wait_quiet();
        set_regs(bpl, iw, ssz);
        set_idle(mode);
        send_random(n);
    endtask

    initial begin
        int p;
        logic [CFG_W-1:0] bpl;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, 640 everywhere
        set_idle(IDLE_NONE);
        send_random(60);

        // directed items on a short line: width 5 inside 8 encoded bytes,
        // padded out to 12
        wait_quiet();
        set_regs(16'd8, 16'd5, 16'd12);
        foreach (directed_seq[k]) send_byte(directed_seq[k]);
        stop_sending();

        // register extremes, then narrow width, no padding and zero padding
        run_phase(16'd1,     16'd1,     16'd1,     IDLE_SEND, 100);
        run_phase(16'hFFFF,  16'hFFFF,  16'hFFFF,  IDLE_RECV, 100);
        run_phase(16'd0,     16'd0,     16'd0,     IDLE_BOTH, 100);
        run_phase(16'd16,    16'd10,    16'd8,     IDLE_NONE, 100);
        run_phase(16'd20,    16'd30,    16'd40,    IDLE_SEND, 100);
        run_phase(16'd0,     16'd5,     16'd3,     IDLE_RECV, 80);
        run_phase(16'd3,     16'd0,     16'd2,     IDLE_BOTH, 80);
        run_phase(16'd64,    16'd64,    16'd0,     IDLE_NONE, 80);

        // long output hold while the sender keeps offering items
        wait_quiet();
        set_regs(16'd12, 16'd8, 16'd20);
        set_idle(IDLE_NONE);
        pressure_on <= 1'b1;
        send_random(120);
        wait_quiet();
        pressure_on <= 1'b0;

        // random small settings, with an occasional extreme
        for (p = 0; p < 6; p++) begin
            bpl = CFG_W'($urandom_range(1, 48));
            if (p == 5) begin
                run_phase(16'hFFFF, 16'd1, 16'd0, p % 4, 60);
            end else begin
                run_phase(bpl, CFG_W'($urandom_range(0, bpl + 4)),
                          CFG_W'($urandom_range(0, 64)), p % 4, 60);
            end
        end

        wait_quiet();
        final_check <= 1'b1;
        @(posedge clk);
        @(posedge clk);

        $display("summary: %0d bytes decoded into %0d items (%0d padding, %0d line ends)",
                 bytes_seen, items_seen, pads_seen, lines_seen);
        $display("summary: %0d register settings, idle and stall mixes, one %0d-cycle hold",
                 settings_cnt, HOLD_LEN);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // safety net in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("timeout: run did not finish");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
